/* rtl/core/rtwe_pkg.sv */
package rtwe_pkg;

  // Field widths
  localparam int TimeW  = 24;
  localparam int ClkW   = 32;
  localparam int DistW  = 31;
  localparam int LoadW  = 22;
  localparam int DemW   = 16;
  localparam int TolW   = 8;

  // Configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_DEPOT_OPEN  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_DEPOT_CLOSE = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_CAPACITY    = CfgIdxW'(2);
  localparam int                 CfgTolIdx       = 3;
  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE   = CfgIdxW'(CfgTolIdx);

  // Stream payload widths
  localparam int InDataW  = 7 * TimeW + DemW;
  localparam int OutBits  = DistW + LoadW + 1;
  localparam int OutDataW = ((OutBits + 7) / 8) * 8;

  typedef struct packed {
    logic [TimeW-1:0] open_time;
    logic [TimeW-1:0] close_time;
    logic [LoadW-1:0] capacity;
    logic [TolW-1:0]  tolerance;
  } cfg_t;

  typedef struct packed {
    logic             has_customer;
    logic [TimeW-1:0] leg_distance;
    logic [TimeW-1:0] leg_time;
    logic [TimeW-1:0] window_open;
    logic [TimeW-1:0] window_close;
    logic [TimeW-1:0] service_time;
    logic [DemW-1:0]  demand;
    logic [TimeW-1:0] return_distance;
    logic [TimeW-1:0] return_time;
    logic             last;
  } item_t;

  // Route totals handed from the accumulator to the closing stage
  typedef struct packed {
    logic             empty;
    logic [DistW-1:0] distance;
    logic [ClkW-1:0]  clock;
    logic [LoadW-1:0] load;
    logic             feasible;
    logic [TimeW-1:0] ret_distance;
    logic [TimeW-1:0] ret_time;
  } fin_t;

  typedef struct packed {
    logic             feasible;
    logic [LoadW-1:0] load;
    logic [DistW-1:0] distance;
  } result_t;

endpackage

/* rtl/core/route_time_window_evaluator.sv */
// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/in_tready  tdata: one route stop, tuser: has_customer,
//                                     tlast: last stop of the route
// out_      out  out_tvalid/out_tready tdata: route totals and feasibility
// cfg_      in   cfg_valid/cfg_ready  cfg_index selects register, cfg_data value
//
// One input beat per cycle sustained while out_ is not stalled; the route clock,
// distance and load sums update once per stop. The beat that closes a route
// reaches out_ through the input register, accumulator totals and output register.
// rst_n is synchronous, active low; flags, config and route sums reset to defaults.
// Stalls on out_ backpressure through the stages to in_tready; a waiting
// result does not stop new stops being taken while a stage is free.
module route_time_window_evaluator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [23:0] leg_distance, [47:24] leg_time, [71:48] window_open,
  // [95:72] window_close, [119:96] service_time, [135:120] demand,
  // [159:136] return_distance, [183:160] return_time
  input  logic [rtwe_pkg::InDataW-1:0]    in_tdata,
  // [0] has_customer
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [30:0] total_distance, [52:31] total_load, [53] route_feasible,
  // [55:54] zero
  output logic [rtwe_pkg::OutDataW-1:0]   out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtwe_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [rtwe_pkg::CfgDataW-1:0]   cfg_data
);
  import rtwe_pkg::*;

  // configuration
  cfg_t    cfg_r;
  logic    open_load;

  // pipeline registers
  item_t   item_r;
  logic    in_valid_r;
  fin_t    fin_r, acc_fin;
  logic    fin_valid_r;
  result_t out_r, close_res;
  logic    out_valid_r;

  logic    out_free, fin_free, acc_fire, acc_done;

  assign cfg_ready = 1'b1;
  assign open_load = cfg_valid && (cfg_index == CFG_DEPOT_OPEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_time  <= '0;
      cfg_r.close_time <= '1;
      cfg_r.capacity   <= '1;
      cfg_r.tolerance  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEPOT_OPEN:  cfg_r.open_time  <= cfg_data[TimeW-1:0];
        CFG_DEPOT_CLOSE: cfg_r.close_time <= cfg_data[TimeW-1:0];
        CFG_CAPACITY:    cfg_r.capacity   <= cfg_data[LoadW-1:0];
        CFG_TOLERANCE:   cfg_r.tolerance  <= cfg_data[TolW-1:0];
        default: ;
      endcase
    end
  end

  // stage flow: each stage moves when the next one is empty or moving
  assign out_free  = !out_valid_r || out_tready;
  assign fin_free  = !fin_valid_r || out_free;
  assign acc_fire  = in_valid_r && fin_free;
  assign acc_done  = !item_r.has_customer || item_r.last;
  assign in_tready = !in_valid_r || acc_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.has_customer    <= in_tuser;
      item_r.leg_distance    <= in_tdata[0*TimeW +: TimeW];
      item_r.leg_time        <= in_tdata[1*TimeW +: TimeW];
      item_r.window_open     <= in_tdata[2*TimeW +: TimeW];
      item_r.window_close    <= in_tdata[3*TimeW +: TimeW];
      item_r.service_time    <= in_tdata[4*TimeW +: TimeW];
      item_r.demand          <= in_tdata[5*TimeW +: DemW];
      item_r.return_distance <= in_tdata[5*TimeW+DemW +: TimeW];
      item_r.return_time     <= in_tdata[6*TimeW+DemW +: TimeW];
      item_r.last            <= in_tlast;
    end
  end

  // running route state; hands over totals when a route closes
  rtwe_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (acc_fire),
    .item      (item_r),
    .cfg       (cfg_r),
    .open_load (open_load),
    .open_data (cfg_data[TimeW-1:0]),
    .fin       (acc_fin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_free) begin
      fin_valid_r <= acc_fire && acc_done;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire && acc_done) begin
      fin_r <= acc_fin;
    end
  end

  // return leg, depot close and capacity checks
  rtwe_close u_close (
    .fin (fin_r),
    .cfg (cfg_r),
    .res (close_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fin_valid_r) begin
      out_r <= close_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutDataW'(out_r);

endmodule

/* rtl/core/rtwe_acc.sv */
module rtwe_acc (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  rtwe_pkg::item_t item,
  input  rtwe_pkg::cfg_t  cfg,
  input  logic           open_load,
  input  logic [rtwe_pkg::TimeW-1:0] open_data,
  output rtwe_pkg::fin_t  fin
);
  import rtwe_pkg::*;

  logic [ClkW-1:0]  clock_r, clock_nxt;
  logic [DistW-1:0] dist_r, dist_nxt;
  logic [LoadW-1:0] load_r, load_nxt;
  logic             feas_r, feas_nxt;

  logic [ClkW:0]    arr_sum, dep_sum;
  logic [ClkW-1:0]  arrive, start, open_ext, due_ext;
  logic [TimeW:0]   due;
  logic [DistW:0]   dist_sum;
  logic [LoadW:0]   load_sum;
  logic             late, over, restart;

  always_comb begin
    // arrival, wait for the window, then service
    arr_sum  = {1'b0, clock_r} + (ClkW+1)'(item.leg_time);
    arrive   = arr_sum[ClkW] ? '1 : arr_sum[ClkW-1:0];
    open_ext = ClkW'(item.window_open);
    start    = (arrive < open_ext) ? open_ext : arrive;
    due      = {1'b0, item.window_close} + (TimeW+1)'(cfg.tolerance);
    due_ext  = ClkW'(due);
    late     = start > due_ext;
    dep_sum  = {1'b0, start} + (ClkW+1)'(item.service_time);
    clock_nxt = dep_sum[ClkW] ? '1 : dep_sum[ClkW-1:0];

    dist_sum = {1'b0, dist_r} + (DistW+1)'(item.leg_distance);
    dist_nxt = dist_sum[DistW] ? '1 : dist_sum[DistW-1:0];

    load_sum = {1'b0, load_r} + (LoadW+1)'(item.demand);
    over     = load_sum[LoadW];
    load_nxt = over ? '1 : load_sum[LoadW-1:0];

    feas_nxt = feas_r & ~late & ~over;
    restart  = ~item.has_customer | item.last;

    fin.empty        = ~item.has_customer;
    fin.distance     = dist_nxt;
    fin.clock        = clock_nxt;
    fin.load         = load_nxt;
    fin.feasible     = feas_nxt;
    fin.ret_distance = item.return_distance;
    fin.ret_time     = item.return_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= '0;
      dist_r  <= '0;
      load_r  <= '0;
      feas_r  <= 1'b1;
    end else if (fire) begin
      if (restart) begin
        clock_r <= ClkW'(cfg.open_time);
        dist_r  <= '0;
        load_r  <= '0;
        feas_r  <= 1'b1;
      end else begin
        clock_r <= clock_nxt;
        dist_r  <= dist_nxt;
        load_r  <= load_nxt;
        feas_r  <= feas_nxt;
      end
    end else if (open_load) begin
      clock_r <= ClkW'(open_data);
    end
  end

endmodule

/* rtl/core/rtwe_close.sv */
module rtwe_close (
  input  rtwe_pkg::fin_t    fin,
  input  rtwe_pkg::cfg_t    cfg,
  output rtwe_pkg::result_t res
);
  import rtwe_pkg::*;

  logic [DistW:0]  dist_sum;
  logic [ClkW:0]   clk_sum;
  logic [ClkW-1:0] arrive, due_ext;
  logic [TimeW:0]  due;
  logic            late, cap_fail;

  always_comb begin
    dist_sum = {1'b0, fin.distance} + (DistW+1)'(fin.ret_distance);
    clk_sum  = {1'b0, fin.clock} + (ClkW+1)'(fin.ret_time);
    arrive   = clk_sum[ClkW] ? '1 : clk_sum[ClkW-1:0];
    due      = {1'b0, cfg.close_time} + (TimeW+1)'(cfg.tolerance);
    due_ext  = ClkW'(due);
    late     = arrive > due_ext;
    cap_fail = fin.load > cfg.capacity;

    if (fin.empty) begin
      res.distance = '0;
      res.load     = '0;
      res.feasible = 1'b1;
    end else begin
      res.distance = dist_sum[DistW] ? '1 : dist_sum[DistW-1:0];
      res.load     = fin.load;
      res.feasible = fin.feasible & ~late & ~cap_fail;
    end
  end

endmodule

/* dv/route_time_window_evaluator_tb.sv */
`timescale 1ns / 1ps

module route_time_window_evaluator_tb;
  import rtwe_pkg::*;

  // Cycles to let a result-less stop clear the pipe (three stages, plus margin)
  localparam int SettleCycles = 8;
  // Cycles with no beat on any channel before the run is declared hung
  localparam int QuietLimit   = 4000;
  // Length of the one long receiver hold-off
  localparam int HoldCycles   = 300;
  // Random stops to offer after the directed part
  localparam int StopBudget   = 600;
  // Stops in one overlong route, enough to saturate distance, load and clock
  localparam int MarathonLen  = 132;

  // Unmapped register indexes, writes there must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = '1;
  localparam logic [TimeW-1:0]   TMAX         = '1;

  typedef enum logic {ROW_STOP, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {STOP_PLAUSIBLE, STOP_NOISE, STOP_HEAVY} flavour_e;

  // One line of the directed plan: either a stop or a register write
  typedef struct {
    row_kind_e            kind;
    item_t                stop;
    bit                   typed;
    result_t              want;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  val;
  } row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [InDataW-1:0]   in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index  = '0;
  logic [CfgDataW-1:0]  cfg_data   = '0;
  wire                  in_tready;
  wire                  out_tvalid;
  wire [OutDataW-1:0]   out_tdata;
  wire                  cfg_ready;

  route_time_window_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // [23:0] leg_distance, [47:24] leg_time, [71:48] window_open,
    // [95:72] window_close, [119:96] service_time, [135:120] demand,
    // [159:136] return_distance, [183:160] return_time
    .in_tdata   (in_tdata),
    // [0] has_customer
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // [30:0] total_distance, [52:31] total_load, [53] route_feasible, [55:54] zero
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow registers, at their reset values
  logic [TimeW-1:0] open_at   = '0;
  logic [TimeW-1:0] close_at  = '1;
  logic [LoadW-1:0] cap_lim   = '1;
  logic [TolW-1:0]  tol_slack = '0;

  // Running route state
  logic [ClkW-1:0]  route_clock = '0;
  logic [DistW-1:0] route_dist  = '0;
  logic [LoadW-1:0] route_load  = '0;
  logic             route_ok    = 1'b1;

  result_t totals_due[$];   // route totals still owed by the block, oldest first
  row_t    plan[$];
  int      mismatches = 0;
  int      stops_sent = 0;
  int      quiet      = 0;
  bit      calm       = 1'b0;  // no idling on either side while set
  bit      hold_req   = 1'b0;  // asks the receiver for its long hold-off

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Route predictor
  // ---------------------------------------------------------------------------
  function automatic void route_restart();
    route_clock = ClkW'(open_at);
    route_dist  = '0;
    route_load  = '0;
    route_ok    = 1'b1;
  endfunction

  // Saturating add on the 32-bit route clock
  function automatic logic [ClkW-1:0] clock_add(logic [ClkW-1:0] a, logic [TimeW-1:0] b);
    logic [ClkW:0] sum;
    sum = {1'b0, a} + b;
    return sum[ClkW] ? '1 : sum[ClkW-1:0];
  endfunction

  function automatic logic [DistW-1:0] dist_add(logic [DistW-1:0] a, logic [TimeW-1:0] b);
    logic [DistW:0] sum;
    sum = {1'b0, a} + b;
    return sum[DistW] ? '1 : sum[DistW-1:0];
  endfunction

  // Advances the route by one stop; returns 1 when the stop closes a route
  function automatic bit route_advance(input item_t s, output result_t r);
    logic [LoadW:0] load_w;
    r = '0;
    if (!s.has_customer) begin
      // empty route: zeros, feasible, and any partial route is dropped
      route_restart();
      r.feasible = 1'b1;
      return 1'b1;
    end
    route_dist  = dist_add(route_dist, s.leg_distance);
    route_clock = clock_add(route_clock, s.leg_time);
    if (route_clock < s.window_open) route_clock = ClkW'(s.window_open);
    if (route_clock > ClkW'(s.window_close) + tol_slack) route_ok = 1'b0;
    route_clock = clock_add(route_clock, s.service_time);
    load_w = {1'b0, route_load} + s.demand;
    if (load_w[LoadW]) begin
      route_load = '1;
      route_ok   = 1'b0;
    end else begin
      route_load = load_w[LoadW-1:0];
    end
    if (!s.last) return 1'b0;
    route_dist  = dist_add(route_dist, s.return_distance);
    route_clock = clock_add(route_clock, s.return_time);
    if (route_clock > ClkW'(close_at) + tol_slack) route_ok = 1'b0;
    if (route_load > cap_lim) route_ok = 1'b0;
    r.distance = route_dist;
    r.load     = route_load;
    r.feasible = route_ok;
    route_restart();
    return 1'b1;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      CFG_DEPOT_OPEN: begin
        open_at     = val[TimeW-1:0];
        route_clock = ClkW'(open_at);   // restarts the clock of a route in progress
      end
      CFG_DEPOT_CLOSE: close_at  = val[TimeW-1:0];
      CFG_CAPACITY:    cap_lim   = val[LoadW-1:0];
      CFG_TOLERANCE:   tol_slack = val[TolW-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t stop_fields(bit cust, logic [TimeW-1:0] ld, logic [TimeW-1:0] lt,
                                        logic [TimeW-1:0] wo, logic [TimeW-1:0] wc,
                                        logic [TimeW-1:0] st, logic [DemW-1:0] dm,
                                        logic [TimeW-1:0] rd, logic [TimeW-1:0] rt, bit last);
    item_t s;
    s.has_customer    = cust;
    s.leg_distance    = ld;
    s.leg_time        = lt;
    s.window_open     = wo;
    s.window_close    = wc;
    s.service_time    = st;
    s.demand          = dm;
    s.return_distance = rd;
    s.return_time     = rt;
    s.last            = last;
    return s;
  endfunction

  function automatic void add_stop(item_t s, bit typed = 1'b0, result_t want = '0);
    row_t row;
    row.kind  = ROW_STOP;
    row.stop  = s;
    row.typed = typed;
    row.want  = want;
    row.idx   = '0;
    row.val   = '0;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    row_t row;
    row.kind  = ROW_REG;
    row.stop  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    row.idx   = idx;
    row.val   = val;
    plan.insert(plan.size(), row);
  endfunction

  // Plausible stops have windows near the predicted clock so both outcomes occur;
  // heavy stops sit near full scale to drive the sums into saturation.
  function automatic item_t draw_stop(flavour_e f, bit last);
    item_t  s;
    longint wo, wc;
    s.has_customer = 1'b1;
    s.last         = last;
    case (f)
      STOP_NOISE: begin
        s.has_customer    = 1'($urandom_range(0, 1));
        s.leg_distance    = TimeW'($urandom);
        s.leg_time        = TimeW'($urandom);
        s.window_open     = TimeW'($urandom);
        s.window_close    = TimeW'($urandom);
        s.service_time    = TimeW'($urandom);
        s.demand          = DemW'($urandom);
        s.return_distance = TimeW'($urandom);
        s.return_time     = TimeW'($urandom);
        s.last            = 1'($urandom_range(0, 1));
      end
      STOP_HEAVY: begin
        s.leg_distance    = TimeW'($urandom_range(24'hFF0000, 24'hFFFFFF));
        s.leg_time        = TimeW'($urandom_range(24'hFF0000, 24'hFFFFFF));
        s.window_open     = '0;
        s.window_close    = TMAX;
        s.service_time    = TimeW'($urandom_range(24'hFF0000, 24'hFFFFFF));
        s.demand          = DemW'($urandom_range(16'hFF00, 16'hFFFF));
        s.return_distance = TimeW'($urandom_range(24'hFF0000, 24'hFFFFFF));
        s.return_time     = TimeW'($urandom_range(24'hFF0000, 24'hFFFFFF));
      end
      default: begin
        s.leg_distance = TimeW'($urandom_range(0, 24'h00FFFF));
        s.leg_time     = TimeW'($urandom_range(0, 24'h000FFF));
        wo = (route_clock > TMAX) ? longint'(TMAX) : longint'(route_clock);
        wo = wo + s.leg_time + $urandom_range(0, 'h1000);
        wo = (wo > 'h800) ? wo - 'h800 : 0;
        if (wo > TMAX) wo = longint'(TMAX);
        wc = wo + $urandom_range(0, 'h800);
        if (wc > TMAX) wc = longint'(TMAX);
        s.window_open     = TimeW'(wo);
        s.window_close    = TimeW'(wc);
        s.service_time    = TimeW'($urandom_range(0, 'h400));
        s.demand          = DemW'($urandom_range(0, 'hFFF));
        s.return_distance = TimeW'($urandom_range(0, 'hFFFF));
        s.return_time     = TimeW'($urandom_range(0, 'hFFF));
      end
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers; valid is left high after a beat so back-to-back stops
  // never see it lowered and raised in one step
  // ---------------------------------------------------------------------------
  task automatic send_stop(input item_t s, input bit typed = 1'b0, input result_t want = '0);
    int      gap;
    result_t got;
    gap = 0;
    if (!calm) while ($urandom_range(0, 99) < 33) gap++;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s.return_time, s.return_distance, s.demand, s.service_time,
                  s.window_close, s.window_open, s.leg_time, s.leg_distance};
    in_tuser  <= s.has_customer;
    in_tlast  <= s.last;
    do @(posedge clk); while (!in_tready);
    stops_sent++;
    // typed rows carry their expectation; the predictor still tracks the route
    if (route_advance(s, got)) totals_due.insert(totals_due.size(), typed ? want : got);
  endtask

  // Quiesce: every owed result out, then let any result-less stop drain
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[OutBits-1:0]);
      if (totals_due.size() == 0) begin
        $display("%0t: route totals with none owed: dist %h load %h feasible %b",
                 $time, got.distance, got.load, got.feasible);
        mismatches++;
      end else begin
        want = totals_due.pop_front();
        if (got.distance !== want.distance) begin
          $display("%0t: total_distance expected %h got %h", $time, want.distance,
                   got.distance);
          mismatches++;
        end
        if (got.load !== want.load) begin
          $display("%0t: total_load expected %h got %h", $time, want.load, got.load);
          mismatches++;
        end
        if (got.feasible !== want.feasible) begin
          $display("%0t: route_feasible expected %b got %b", $time, want.feasible,
                   got.feasible);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QuietLimit) begin
      $display("%0t: no beat for %0d cycles, %0d results owed", $time, quiet,
               totals_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    item_t               s;
    int                  route_no;
    int                  len;
    int                  pick;
    int                  sel;
    int                  marathons;
    logic [CfgDataW-1:0] v;

    // Directed plan, default registers first
    add_stop(stop_fields(0, TMAX, TMAX, TMAX, TMAX, TMAX, '1, TMAX, TMAX, 0), 1'b1,
             '{1'b1, '0, '0});                          // empty route, last low
    add_stop(stop_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, '{1'b1, '0, '0});
    add_stop(stop_fields(1, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, '{1'b1, '0, '0});
    // all fields full scale: window met, but return overshoots the depot close
    add_stop(stop_fields(1, TMAX, TMAX, TMAX, TMAX, TMAX, '1, TMAX, TMAX, 1), 1'b1,
             '{1'b0, 22'h00FFFF, 31'h1FFFFFE});
    add_stop(stop_fields(1, 'h40, 'h200, 'h100, 'h1FF, 0, 5, 'h40, 'h10, 1));  // late
    add_stop(stop_fields(1, 'h10, 'h10, 'h1000, 'h2000, 'h100, 'h20, 0, 0, 0)); // waits
    add_stop(stop_fields(1, 'h10, 'h10, 0, 'h1100, 0, 'h20, 'h30, 'h40, 1));
    // partial route dropped by an empty item
    add_stop(stop_fields(1, 'h99, 'h99, 0, TMAX, 0, 'h77, 0, 0, 0));
    add_stop(stop_fields(0, 1, 1, 1, 1, 1, 1, 1, 1, 0), 1'b1, '{1'b1, '0, '0});
    // tight depot, capacity data with bits above its width
    add_reg(CFG_TOLERANCE, 'hFF);
    add_reg(CFG_DEPOT_CLOSE, 'h400);
    add_reg(CFG_CAPACITY, 24'hC00010);
    add_reg(CFG_DEPOT_OPEN, 'h100);
    add_stop(stop_fields(1, 1, 0, 0, TMAX, 0, 'h11, 1, 0, 1));       // over capacity
    add_stop(stop_fields(1, 'h20, 'h100, 0, 'h101, 0, 'h10, 'h20, 'h2FF, 1)); // on the slack
    add_stop(stop_fields(1, 'h20, 'h100, 0, 'h101, 0, 'h10, 'h20, 'h300, 1)); // one past
    // open time rewritten mid-route restarts the clock
    add_stop(stop_fields(1, 'h5, 'h50, 0, TMAX, 'h10, 1, 0, 0, 0));
    add_reg(CFG_DEPOT_OPEN, 'h0);
    add_stop(stop_fields(1, 'h5, 'h50, 0, 'h60, 0, 1, 'h5, 'h50, 1));
    // unmapped indexes
    add_reg(CFG_SPARE_LO, TMAX);
    add_reg(CFG_SPARE_HI, '0);
    add_stop(stop_fields(1, 0, 'h300, 0, 'h300, 0, 'h10, 0, 'h1FF, 1));
    // register extremes the other way
    add_reg(CFG_DEPOT_OPEN, TMAX);
    add_reg(CFG_DEPOT_CLOSE, '0);
    add_reg(CFG_CAPACITY, '0);
    add_reg(CFG_TOLERANCE, 'hFF);
    add_stop(stop_fields(1, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, '{1'b0, '0, '0});
    add_stop(stop_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, '{1'b1, '0, '0});
    add_reg(CFG_DEPOT_OPEN, '0);
    add_reg(CFG_DEPOT_CLOSE, TMAX);
    add_reg(CFG_CAPACITY, 24'h3FFFFF);
    add_reg(CFG_TOLERANCE, '0);
    add_stop(stop_fields(1, 0, 0, 0, 0, 0, '1, 0, 0, 1), 1'b1, '{1'b1, 22'h00FFFF, '0});

    // Reset
    route_restart();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].val);
      else send_stop(plan[i].stop, plan[i].typed, plan[i].want);
    end

    // Random routes
    route_no  = 0;
    marathons = 0;
    stops_sent = 0;
    while (stops_sent < StopBudget) begin
      if (route_no % 12 == 0) begin
        for (int r = 0; r <= CfgTolIdx; r++) begin
          sel = $urandom_range(0, 7);
          case (CfgIdxW'(r))
            CFG_DEPOT_OPEN:
              v = (sel == 0) ? '0 : (sel == 1) ? TMAX
                                               : CfgDataW'($urandom_range(0, 'h8000));
            CFG_DEPOT_CLOSE:
              v = (sel == 0) ? '0 : (sel == 1) ? TMAX
                  : CfgDataW'(open_at + $urandom_range('h1000, 'h40000));
            CFG_CAPACITY:
              v = (sel == 0) ? '0 : (sel == 1) ? CfgDataW'($urandom)
                                               : CfgDataW'($urandom_range('h800, 'h8000));
            default:
              v = (sel == 0) ? '0 : (sel == 1) ? CfgDataW'('hFF)
                  : (sel == 2) ? CfgDataW'($urandom) : CfgDataW'($urandom_range(0, 'hFF));
          endcase
          write_reg(CfgIdxW'(r), v);
        end
        if (sel < 2) write_reg(CfgIdxW'($urandom_range(4, 255)), CfgDataW'($urandom));
      end

      calm = (route_no >= 60 && route_no < 90);
      if (route_no == 30) hold_req = 1'b1;   // receiver stops; single-stop routes fill the pipe

      pick = $urandom_range(0, 99);
      if (route_no == 20 || (marathons == 1 && stops_sent >= 420)) begin
        // overlong route saturating distance, load and clock
        marathons++;
        for (int i = 0; i < MarathonLen; i++)
          send_stop(draw_stop(STOP_HEAVY, i == MarathonLen - 1));
      end else if (hold_req || pick < 70) begin
        len = hold_req ? 1 :
              ($urandom_range(0, 9) == 0) ? $urandom_range(7, 64) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send_stop(draw_stop(STOP_PLAUSIBLE, i == len - 1));
      end else if (pick < 82) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
          send_stop(draw_stop(STOP_NOISE, 1'b0));
      end else if (pick < 90) begin
        s = draw_stop(STOP_NOISE, 1'b0);
        s.has_customer = 1'b0;
        send_stop(s);
      end else begin
        // route cut short by an empty item
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          send_stop(draw_stop(STOP_PLAUSIBLE, 1'b0));
        s = draw_stop(STOP_NOISE, 1'b0);
        s.has_customer = 1'b0;
        send_stop(s);
      end
      route_no++;
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
